>>> hdl/scc_pkg.sv
// Shared types and constants for the seam cumulative cost block.
// No dependencies; every other file in hdl/ imports this package.
package scc_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int MAX_HEIGHT   = 4096;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = HEIGHT_REG_W;
   localparam int CSR_INDEX_W  = 1;
   localparam int ENERGY_W     = 8;
   localparam int COST_W       = 20;

   localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // Position of one pixel in the frame, as seen when it is taken in.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             first;
      logic             last;
      logic             rend;
   } pos_type;

endpackage

>>> hdl/scc_line_buffer.sv
// Line buffer holding the previous row's path costs, one entry per column.
// One write port and one registered read port. Depends on scc_pkg.
module scc_line_buffer (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [scc_pkg::COL_W-1:0]   wr_addr,
   input  logic [scc_pkg::COST_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [scc_pkg::COL_W-1:0]   rd_addr,
   output logic [scc_pkg::COST_W-1:0]  rd_data
);
   import scc_pkg::*;

   logic [COST_W-1:0] mem [MAX_WIDTH];
   logic [COST_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/scc_scan_ctrl.sv
// Size registers and raster counters: yields the position and row flags of
// the pixel about to be taken in. Depends on scc_pkg.
module scc_scan_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [scc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [scc_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                               advance,
   output scc_pkg::pos_type                   pos
);
   import scc_pkg::*;

   logic [WIDTH_REG_W-1:0]  image_width_ff;
   logic [HEIGHT_REG_W-1:0] image_height_ff;
   logic [COL_W-1:0]        col_ff;
   logic [COL_W-1:0]        col_in;
   logic [ROW_W-1:0]        row_ff;
   logic [ROW_W-1:0]        row_in;
   logic [COL_W:0]          width_eff;
   logic [ROW_W:0]          height_eff;
   logic                    last_row;
   logic                    row_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= WIDTH_REG_W'(MAX_WIDTH);
         image_height_ff <= HEIGHT_REG_W'(MAX_HEIGHT);
      end else if (csr_write) begin
         case (reg_index_type'(csr_index))
            REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[WIDTH_REG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               image_height_ff <= csr_data[HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A size of zero counts as one, a size beyond the buffer as the maximum.
   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = (COL_W+1)'(1);
      end else if (image_width_ff > WIDTH_REG_W'(MAX_WIDTH)) begin
         width_eff = (COL_W+1)'(MAX_WIDTH);
      end else begin
         width_eff = (COL_W+1)'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         height_eff = (ROW_W+1)'(1);
      end else if (image_height_ff > HEIGHT_REG_W'(MAX_HEIGHT)) begin
         height_eff = (ROW_W+1)'(MAX_HEIGHT);
      end else begin
         height_eff = (ROW_W+1)'(image_height_ff);
      end
   end

   always_comb begin
      row_end  = ({1'b0, col_ff} + (COL_W+1)'(1)) >= width_eff;
      last_row = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= height_eff;
      if (row_end) begin
         col_in = '0;
         row_in = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         col_in = col_ff + COL_W'(1);
         row_in = row_ff;
      end
      pos.col   = col_ff;
      pos.first = (row_ff == '0);
      pos.last  = last_row;
      pos.rend  = row_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

>>> hdl/scc_cost_unit.sv
// Picks the cheapest of up to three parents (leftmost wins on a tie) and adds
// the pixel energy with saturation. Purely combinational. Depends on scc_pkg.
module scc_cost_unit (
   input  logic [scc_pkg::ENERGY_W-1:0]  energy,
   input  scc_pkg::pos_type              pos,
   input  logic [scc_pkg::COST_W-1:0]    left_cost,
   input  logic [scc_pkg::COST_W-1:0]    centre_cost,
   input  logic [scc_pkg::COST_W-1:0]    right_cost,
   output logic [scc_pkg::COST_W-1:0]    cum_cost,
   output logic [scc_pkg::COL_W-1:0]     parent_column
);
   import scc_pkg::*;

   logic [COST_W-1:0] best;
   logic [COL_W-1:0]  parent;
   logic [COST_W:0]   sum;

   always_comb begin
      if (pos.col != '0) begin
         best   = left_cost;
         parent = pos.col - COL_W'(1);
         if (centre_cost < best) begin
            best   = centre_cost;
            parent = pos.col;
         end
      end else begin
         best   = centre_cost;
         parent = pos.col;
      end
      // A right neighbour exists exactly when this is not the row's last pixel.
      if (!pos.rend && (right_cost < best)) begin
         best   = right_cost;
         parent = pos.col + COL_W'(1);
      end
      sum = {1'b0, best} + (COST_W+1)'(energy);
      if (pos.first) begin
         cum_cost      = COST_W'(energy);
         parent_column = '0;
      end else begin
         cum_cost      = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
         parent_column = parent;
      end
   end

endmodule

>>> hdl/seam_cumulative_cost.sv
// Seam cumulative cost: streaming vertical minimum-path accumulator.
//
// Energy pixels arrive on the req_ channel in raster order, one beat per
// pixel, and each yields exactly one rsp_ beat: the minimum cumulative cost
// of a vertical path ending at the pixel, the column of the chosen parent in
// the row above, and first/last row and end-of-row flags. The csr_ channel
// writes the image width (index 0) and height (index 1); it is always ready
// and is meant to be written only while no pixel is in flight.
//
// A pixel taken in is registered in the cost stage and moves on into the
// output register once that register is free; rsp_valid is driven from the
// output register. Throughput is one pixel per cycle while rsp_ready stays
// high: the line buffer is read one column ahead, so the three candidate
// costs are ready when the pixel reaches the cost stage. The single line
// buffer read port sets that figure.
//
// When the receiver holds rsp_ready low the result stays in the output
// register; the pixel behind it waits in the cost stage and req_ready drops
// only once both are full. Reset clears the counters, restores the maximum
// image size and empties the pipeline; the line buffer is not cleared, as
// each entry is written by the row above before it is read.
// Depends on scc_pkg, scc_scan_ctrl, scc_line_buffer and scc_cost_unit.
module seam_cumulative_cost (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [scc_pkg::ENERGY_W-1:0]      req_energy,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [scc_pkg::COST_W-1:0]        rsp_cum_cost,
   output logic [scc_pkg::COL_W-1:0]         rsp_parent_column,
   output logic                              rsp_first_row,
   output logic                              rsp_last_row,
   output logic                              rsp_row_end,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [scc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import scc_pkg::*;

   // Handshake control.
   logic              accept;
   logic              s1_advance;
   logic              out_free;

   // Position of the pixel being taken in.
   pos_type           in_pos;

   // Cost stage register.
   logic              s1_valid_ff;
   pos_type           s1_pos_ff;
   logic [ENERGY_W-1:0] s1_energy_ff;

   // Sliding window over the previous row.
   logic [COST_W-1:0] left_ff;
   logic [COST_W-1:0] centre_window_ff;
   logic [COST_W-1:0] col0_cost_ff;
   logic              bypass_hit_ff;
   logic [COST_W-1:0] bypass_data_ff;

   logic [COST_W-1:0] rd_data;
   logic [COST_W-1:0] right_cost;
   logic [COST_W-1:0] centre_cost;
   logic [COST_W-1:0] cost;
   logic [COL_W-1:0]  parent;
   logic [COL_W-1:0]  rd_addr;

   // Output register.
   logic              rsp_valid_ff;
   logic [COST_W-1:0] rsp_cum_cost_ff;
   logic [COL_W-1:0]  rsp_parent_column_ff;
   logic              rsp_first_row_ff;
   logic              rsp_last_row_ff;
   logic              rsp_row_end_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign accept     = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   scc_scan_ctrl u_scan_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (accept),
      .pos       (in_pos)
   );

   // The buffer is read at the column to the right of the incoming pixel.
   // The previous pixel writes its own column in the same cycle, so a read of
   // that address is served from the bypass register instead.
   assign rd_addr = in_pos.col + COL_W'(1);

   scc_line_buffer u_line_buffer (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_pos_ff.col),
      .wr_data (cost),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pos_ff      <= in_pos;
         s1_energy_ff   <= req_energy;
         bypass_hit_ff  <= s1_advance && (s1_pos_ff.col == rd_addr);
         bypass_data_ff <= cost;
      end
   end

   // The up cost of a pixel is the right cost fetched for its left
   // neighbour; column zero has no such neighbour and uses its own register.
   assign right_cost  = bypass_hit_ff ? bypass_data_ff : rd_data;
   assign centre_cost = (s1_pos_ff.col == '0) ? col0_cost_ff : centre_window_ff;

   scc_cost_unit u_cost_unit (
      .energy        (s1_energy_ff),
      .pos           (s1_pos_ff),
      .left_cost     (left_ff),
      .centre_cost   (centre_cost),
      .right_cost    (right_cost),
      .cum_cost      (cost),
      .parent_column (parent)
   );

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         left_ff          <= centre_cost;
         centre_window_ff <= right_cost;
         if (s1_pos_ff.col == '0) begin
            col0_cost_ff <= cost;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_cum_cost_ff      <= cost;
         rsp_parent_column_ff <= parent;
         rsp_first_row_ff     <= s1_pos_ff.first;
         rsp_last_row_ff      <= s1_pos_ff.last;
         rsp_row_end_ff       <= s1_pos_ff.rend;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cum_cost      = rsp_cum_cost_ff;
   assign rsp_parent_column = rsp_parent_column_ff;
   assign rsp_first_row     = rsp_first_row_ff;
   assign rsp_last_row      = rsp_last_row_ff;
   assign rsp_row_end       = rsp_row_end_ff;

endmodule

>>> hdl/scc_checker.sv
// Port-level checks for seam_cumulative_cost, attached by the bind below.
// Depends on scc_pkg and the top level's port list.
module scc_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [scc_pkg::COST_W-1:0]        rsp_cum_cost,
   input  logic [scc_pkg::COL_W-1:0]         rsp_parent_column,
   input  logic                              rsp_first_row,
   input  logic                              rsp_last_row,
   input  logic                              rsp_row_end
);
   import scc_pkg::*;

   // A stalled result beat holds its payload.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cum_cost)
         && $stable(rsp_parent_column) && $stable(rsp_first_row)
         && $stable(rsp_last_row) && $stable(rsp_row_end))
      else $error("result beat changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A result appearing on an idle output came from an accepted request beat that passed through the cost stage.
   a_rsp_from_req : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without a matching request beat");

   // A top-row result has no parent and carries only its own energy.
   a_first_row : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_row |->
         rsp_parent_column == '0 && rsp_cum_cost <= COST_W'((1 << ENERGY_W) - 1))
      else $error("top-row result with a parent or excess cost");

endmodule

bind seam_cumulative_cost scc_checker u_scc_checker (.*);
